// ===== hdl/ectc_pkg.sv =====
// Shared types and constants for the epoch seconds to calendar converter.
// Used by ectc_ctrl, ectc_dp and the top level epoch_seconds_to_calendar.
package ectc_pkg;

  // Divider operations, issued in this order
  localparam logic [1:0] OP_DAY  = 2'd0;  // count / 86400
  localparam logic [1:0] OP_WDAY = 2'd1;  // (days + 6) / 7
  localparam logic [1:0] OP_HOUR = 2'd2;  // tod / 3600
  localparam logic [1:0] OP_MIN  = 2'd3;  // rest / 60

  localparam int unsigned IDX_W    = 8;   // year index, covers spans up to 136 years
  localparam int unsigned DIVD_W   = 25;  // widest dividend (count[31:7])
  localparam int unsigned RECIP_W  = 26;  // widest reciprocal (day step)
  localparam int unsigned PROD_W   = DIVD_W + RECIP_W;
  localparam int unsigned DIVR_W   = 12;  // widest divisor (3600)
  localparam int unsigned QUO_W    = 16;  // widest quotient (days)

  // Reciprocal shifts: quotient = (dividend * recip) >> shift
  localparam int unsigned SH_DAY  = 35;
  localparam int unsigned SH_WDAY = 19;
  localparam int unsigned SH_HOUR = 29;
  localparam int unsigned SH_MIN  = 18;

  localparam logic [11:0] FIRST_YEAR   = 12'd2000;
  localparam logic [15:0] FIRST_WEEKDAY = 16'd6;
  localparam logic [3:0]  LAST_MONTH   = 4'd11;
  localparam logic [IDX_W-1:0] NONLEAP_CENTURY = IDX_W'(100);  // year 2100

  // Controller to datapath commands
  typedef struct packed {
    logic       accept;    // latch the input count
    logic [1:0] op;        // current divider operation
    logic       div_load;  // load dividend for op
    logic       div_mul;   // multiply dividend by reciprocal
    logic       div_cap;   // capture quotient and remainder for op
    logic       yr_init;   // clear year and month walk
    logic       yr_step;   // subtract year length, next year
    logic       mo_step;   // subtract month length, next month
    logic       set_err;   // count beyond span
    logic       publish;   // update result registers
  } ectc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic yr_over;  // index reached the end of the span
    logic yr_fit;   // remaining days lie inside the current year
    logic mo_fit;   // remaining days lie inside the current month
  } ectc_sts_t;

  // Divisor for each operation; the day step divides count[31:7] by 86400 / 128
  function automatic logic [DIVR_W-1:0] op_divisor(input logic [1:0] op);
    logic [DIVR_W-1:0] d;
    case (op)
      OP_DAY:  d = DIVR_W'(675);
      OP_WDAY: d = DIVR_W'(7);
      OP_HOUR: d = DIVR_W'(3600);
      OP_MIN:  d = DIVR_W'(60);
      default: d = DIVR_W'(1);
    endcase
    return d;
  endfunction

  // Rounded-up reciprocal per operation, exact over the dividend range of each
  function automatic logic [RECIP_W-1:0] op_recip(input logic [1:0] op);
    logic [RECIP_W-1:0] r;
    case (op)
      OP_DAY:  r = RECIP_W'(50903317);  // 2^35 / 675, 25-bit dividend
      OP_WDAY: r = RECIP_W'(74899);     // 2^19 / 7, 16-bit dividend
      OP_HOUR: r = RECIP_W'(149131);    // 2^29 / 3600, 17-bit dividend
      OP_MIN:  r = RECIP_W'(4370);      // 2^18 / 60, 12-bit dividend
      default: r = '0;
    endcase
    return r;
  endfunction

  // Month length, February depends on leap year
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] l;
    case (m)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: l = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   l = 5'd30;
      4'd1:    l = leap ? 5'd29 : 5'd28;
      default: l = 5'd31;
    endcase
    return l;
  endfunction

endpackage

// ===== hdl/ectc_dp.sv =====
// Datapath of the calendar converter: shared reciprocal-multiplication
// divider, year and month walk, result registers. Depends on ectc_pkg.
module ectc_dp #(
  parameter int unsigned YEAR_SPAN = 100
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ectc_pkg::ectc_cmd_t cmd_i,
  output ectc_pkg::ectc_sts_t sts_o,
  input  logic [31:0]         seconds_count_i,
  output logic [11:0]         year_o,
  output logic [3:0]          month_o,
  output logic [4:0]          day_of_month_o,
  output logic [4:0]          hour_o,
  output logic [5:0]          minute_o,
  output logic [5:0]          second_o,
  output logic [2:0]          weekday_o,
  output logic                range_error_o
);
  import ectc_pkg::*;

  logic [31:0]        count_q;
  logic [DIVD_W-1:0]  divd_q;
  logic [PROD_W-1:0]  prod_q;
  logic [15:0]        days_q;
  logic [16:0]        tod_q;
  logic [11:0]        mrem_q;
  logic [2:0]         wday_q;
  logic [4:0]         hour_q;
  logic [5:0]         min_q, sec_q;
  logic [IDX_W-1:0]   idx_q;
  logic [3:0]         mon_q;
  logic               err_q;

  logic [DIVR_W-1:0]       divisor;
  logic [RECIP_W-1:0]      recip;
  logic [DIVD_W-1:0]       dividend;
  logic [QUO_W-1:0]        quo;
  logic [QUO_W+DIVR_W-1:0] qd;
  logic [QUO_W+DIVR_W-1:0] diff;
  logic [DIVR_W-1:0]       rem;
  logic [15:0]             days_wk;
  logic                    leap;
  logic [8:0]              ylen;
  logic [4:0]              mlen;

  assign divisor = op_divisor(cmd_i.op);
  assign recip   = op_recip(cmd_i.op);
  assign days_wk = days_q + FIRST_WEEKDAY;

  // Dividend for each operation; 86400 = 128 * 675, so the day step
  // divides count[31:7] and the low seven bits pass into time of day
  always_comb begin
    case (cmd_i.op)
      OP_DAY:  dividend = count_q[31:7];
      OP_WDAY: dividend = {9'b0, days_wk};
      OP_HOUR: dividend = {8'b0, tod_q};
      OP_MIN:  dividend = {13'b0, mrem_q};
      default: dividend = count_q[31:7];
    endcase
  end

  // Quotient from the upper product bits
  always_comb begin
    case (cmd_i.op)
      OP_DAY:  quo = prod_q[SH_DAY +: QUO_W];
      OP_WDAY: quo = prod_q[SH_WDAY +: QUO_W];
      OP_HOUR: quo = prod_q[SH_HOUR +: QUO_W];
      OP_MIN:  quo = prod_q[SH_MIN +: QUO_W];
      default: quo = prod_q[SH_DAY +: QUO_W];
    endcase
  end

  // Remainder = dividend - quotient * divisor
  assign qd   = {{DIVR_W{1'b0}}, quo} * {{QUO_W{1'b0}}, divisor};
  assign diff = {{(QUO_W+DIVR_W-DIVD_W){1'b0}}, divd_q} - qd;
  assign rem  = diff[DIVR_W-1:0];

  // Leap rule inside 2000..2135: every fourth year except 2100
  assign leap = (idx_q[1:0] == 2'b00) && (idx_q != NONLEAP_CENTURY);
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = month_len(mon_q, leap);

  assign sts_o.yr_over = (idx_q == IDX_W'(YEAR_SPAN));
  assign sts_o.yr_fit  = (days_q < {7'b0, ylen});
  assign sts_o.mo_fit  = (days_q < {11'b0, mlen}) || (mon_q == LAST_MONTH);

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      count_q <= seconds_count_i;
    end
    if (cmd_i.div_load) begin
      divd_q <= dividend;
    end
    if (cmd_i.div_mul) begin
      prod_q <= {{RECIP_W{1'b0}}, divd_q} * {{DIVD_W{1'b0}}, recip};
    end
    if (cmd_i.div_cap) begin
      case (cmd_i.op)
        OP_DAY: begin
          days_q <= quo;
          tod_q  <= {rem[9:0], count_q[6:0]};
        end
        OP_WDAY: begin
          wday_q <= rem[2:0];
        end
        OP_HOUR: begin
          hour_q <= quo[4:0];
          mrem_q <= rem;
        end
        OP_MIN: begin
          min_q <= quo[5:0];
          sec_q <= rem[5:0];
        end
        default: begin
          days_q <= days_q;
        end
      endcase
    end else if (cmd_i.yr_step) begin
      days_q <= days_q - {7'b0, ylen};
    end else if (cmd_i.mo_step) begin
      days_q <= days_q - {11'b0, mlen};
    end
  end

  // Year and month walk counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      mon_q <= '0;
      err_q <= 1'b0;
    end else if (cmd_i.yr_init) begin
      idx_q <= '0;
      mon_q <= '0;
      err_q <= 1'b0;
    end else begin
      if (cmd_i.yr_step) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.mo_step) begin
        mon_q <= mon_q + 1'b1;
      end
      if (cmd_i.set_err) begin
        err_q <= 1'b1;
      end
    end
  end

  // Result registers, held until the next publish
  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      year_o         <= err_q ? 12'd0 : FIRST_YEAR + {{(12-IDX_W){1'b0}}, idx_q};
      month_o        <= err_q ? 4'd0 : mon_q + 4'd1;
      day_of_month_o <= err_q ? 5'd0 : days_q[4:0] + 5'd1;
      hour_o         <= hour_q;
      minute_o       <= min_q;
      second_o       <= sec_q;
      weekday_o      <= wday_q;
      range_error_o  <= err_q;
    end
  end

endmodule

// ===== hdl/ectc_ctrl.sv =====
// Sequencer of the calendar converter: runs the four divisions, then the
// year and month walk, then publishes. Depends on ectc_pkg.
module ectc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  output logic                valid_o,
  output ectc_pkg::ectc_cmd_t cmd_o,
  input  ectc_pkg::ectc_sts_t sts_i
);
  import ectc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_CAP   = 3'd3;
  localparam logic [2:0] S_YEAR  = 3'd4;
  localparam logic [2:0] S_MONTH = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_q, state_d;
  logic [1:0] op_q, op_d;
  logic       valid_q, valid_d;

  assign busy    = (state_q != S_IDLE);
  assign valid_o = valid_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    valid_d = 1'b0;
    cmd_o   = '0;
    cmd_o.op = op_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          op_d    = OP_DAY;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.div_load = 1'b1;
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.div_mul = 1'b1;
        state_d = S_CAP;
      end
      S_CAP: begin
        cmd_o.div_cap = 1'b1;
        if (op_q == OP_MIN) begin
          cmd_o.yr_init = 1'b1;
          state_d = S_YEAR;
        end else begin
          op_d    = op_q + 2'd1;
          state_d = S_LOAD;
        end
      end
      S_YEAR: begin
        if (sts_i.yr_over) begin
          cmd_o.set_err = 1'b1;
          state_d = S_DONE;
        end else if (sts_i.yr_fit) begin
          state_d = S_MONTH;
        end else begin
          cmd_o.yr_step = 1'b1;
        end
      end
      S_MONTH: begin
        if (sts_i.mo_fit) begin
          state_d = S_DONE;
        end else begin
          cmd_o.mo_step = 1'b1;
        end
      end
      S_DONE: begin
        cmd_o.publish = 1'b1;
        valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_DAY;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      valid_q <= valid_d;
    end
  end

endmodule

// ===== hdl/epoch_seconds_to_calendar.sv =====
// Converts seconds since 2000-01-01 00:00:00 into calendar date, time and
// weekday. The block takes a count when start is high and busy is low, and
// busy then stays high while it runs four divisions (by 86400, 7, 3600 and
// 60) by reciprocal multiplication, each a load, a multiply and a
// quotient/remainder capture, then the year and month walk, one year or
// month a cycle, up to YEAR_SPAN - 1 years and 11 months, then publishes.
// A count past the span walks YEAR_SPAN years and skips the month walk.
// The result appears for exactly one cycle with valid_o high, the first
// cycle with busy low, and the receiver cannot stall it; the result ports
// hold it until the next one.
// Counts past the last year of the span set range_error_o and give zero
// year, month and day; time of day and weekday stay valid.
// Depends on ectc_pkg, ectc_ctrl, ectc_dp.
module epoch_seconds_to_calendar #(
  parameter int unsigned YEAR_SPAN = 100
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] seconds_count_i,
  output logic        valid_o,
  output logic [11:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_of_month_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o,
  output logic [2:0]  weekday_o,
  output logic        range_error_o
);
  import ectc_pkg::*;

  ectc_cmd_t cmd;
  ectc_sts_t sts;

  ectc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .valid_o (valid_o),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  ectc_dp #(
    .YEAR_SPAN (YEAR_SPAN)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .seconds_count_i (seconds_count_i),
    .year_o          (year_o),
    .month_o         (month_o),
    .day_of_month_o  (day_of_month_o),
    .hour_o          (hour_o),
    .minute_o        (minute_o),
    .second_o        (second_o),
    .weekday_o       (weekday_o),
    .range_error_o   (range_error_o)
  );

endmodule
